// ----- src/nearest_neighbor_scale_addresser_defines.svh -----
// Assertion helpers shared by the addresser modules.
// Each expects clk and rst in scope; checks are off while rst is high.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESSER_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESSER_DEFINES_SVH

// Same-cycle implication.
`define NNSA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NNSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nnsa_pkg.sv -----
package nnsa_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);    // size registers
  localparam int IDX_W   = $clog2(MAX_DIM);        // positions, addresses
  localparam int PROD_W  = IDX_W + DIM_W;          // k * src
  localparam int CNT_W   = $clog2(PROD_W + 1);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 4 * IDX_W;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_MIRROR_X   = 3'd4,
    REG_MIRROR_Y   = 3'd5
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;     // accept item, resolve start position
    logic start_col;   // launch column divide
    logic cap_col;     // capture column quotient
    logic start_row;   // launch row divide
    logic cap_row;     // capture row quotient
    logic load_out;    // fill output register, step position
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/nnsa_div.sv -----
`include "nearest_neighbor_scale_addresser_defines.svh"

// floor(kk * scale / divisor): the product is registered on start, then one quotient bit per cycle.
module nnsa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nnsa_pkg::IDX_W-1:0]  kk,
  input  logic [nnsa_pkg::DIM_W-1:0]  scale,
  input  logic [nnsa_pkg::DIM_W-1:0]  divisor,
  output logic                        done,
  output logic [nnsa_pkg::IDX_W-1:0]  quotient
);

  logic                         busy;
  logic [nnsa_pkg::CNT_W-1:0]   cnt;
  logic [nnsa_pkg::PROD_W-1:0]  dvd;
  logic [nnsa_pkg::DIM_W-1:0]   rem;
  logic [nnsa_pkg::DIM_W-1:0]   dsr;

  logic [nnsa_pkg::DIM_W:0]     rem_sh;
  logic                         ge;
  logic [nnsa_pkg::DIM_W:0]     rem_sub;

  always_comb begin
    rem_sh  = {rem, dvd[nnsa_pkg::PROD_W-1]};
    ge      = (rem_sh >= {1'b0, dsr});
    rem_sub = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nnsa_pkg::CNT_W'(nnsa_pkg::PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == nnsa_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= nnsa_pkg::PROD_W'(kk) * nnsa_pkg::PROD_W'(scale);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dvd <= {dvd[nnsa_pkg::PROD_W-2:0], ge};
      rem <= ge ? rem_sub[nnsa_pkg::DIM_W-1:0] : rem_sh[nnsa_pkg::DIM_W-1:0];
    end
  end

  assign quotient = dvd[nnsa_pkg::IDX_W-1:0];

  `NNSA_ASSERT_NEXT(a_start_busy, start, busy, "divider did not go busy after start")
  `NNSA_ASSERT_IMPLIES(a_rem_bound, busy && !start, rem < dsr, "partial remainder reached divisor")

endmodule

// ----- src/nnsa_ctrl.sv -----
module nnsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  nnsa_pkg::dp_status_t status,
  output nnsa_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    IDLE      = 5'b00001,
    COL_START = 5'b00010,
    COL_WAIT  = 5'b00100,
    ROW_WAIT  = 5'b01000,
    LOAD      = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = COL_START;
        end
      end
      COL_START: begin
        cmd.start_col = 1'b1;
        state_next    = COL_WAIT;
      end
      COL_WAIT: begin
        if (status.div_done) begin
          cmd.cap_col   = 1'b1;
          cmd.start_row = 1'b1;
          state_next    = ROW_WAIT;
        end
      end
      ROW_WAIT: begin
        if (status.div_done) begin
          cmd.cap_row = 1'b1;
          state_next  = LOAD;
        end
      end
      LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/nnsa_dp.sv -----
`include "nearest_neighbor_scale_addresser_defines.svh"

module nnsa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  nnsa_pkg::ctrl_cmd_t               cmd,
  output nnsa_pkg::dp_status_t              status,
  input  logic                              restart,
  input  logic                              cfg_we,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nnsa_pkg::OUT_TDATA_W-1:0]  out_data,
  output logic                              out_last,
  output logic [nnsa_pkg::OUT_TUSER_W-1:0]  out_user
);

  localparam int DW = nnsa_pkg::DIM_W;
  localparam int IW = nnsa_pkg::IDX_W;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DW'(1);
    end else if (v > DW'(nnsa_pkg::MAX_DIM)) begin
      r = DW'(nnsa_pkg::MAX_DIM);
    end
    return r;
  endfunction

  // configuration
  logic [DW-1:0] src_width, src_height, dst_width, dst_height;
  logic          mirror_x, mirror_y;

  // walk state
  logic [IW-1:0] cur_col, cur_row, prev_src_row;
  logic [IW-1:0] col_q, row_q;

  // output register
  logic [IW-1:0] out_src_col, out_src_row, out_dst_col, out_dst_row;
  logic          out_rep, out_eor, out_eof;

  logic [DW-1:0] sw, sh, dw, dh, dw_m1, dh_m1;
  logic [IW-1:0] kk_col, kk_row;
  logic          wrap;
  logic          eor, eof, rep;
  logic          div_start, div_done;
  logic [IW-1:0] div_kk, div_quot;
  logic [DW-1:0] div_scale, div_dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DW'(1);
      src_height <= DW'(1);
      dst_width  <= DW'(1);
      dst_height <= DW'(1);
      mirror_x   <= 1'b0;
      mirror_y   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnsa_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        nnsa_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        nnsa_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data;
        nnsa_pkg::REG_DST_HEIGHT: dst_height <= cfg_data;
        nnsa_pkg::REG_MIRROR_X:   mirror_x   <= cfg_data[0];
        nnsa_pkg::REG_MIRROR_Y:   mirror_y   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw    = clamp_dim(src_width);
    sh    = clamp_dim(src_height);
    dw    = clamp_dim(dst_width);
    dh    = clamp_dim(dst_height);
    dw_m1 = dw - DW'(1);
    dh_m1 = dh - DW'(1);
    wrap  = restart || ({1'b0, cur_col} >= dw) || ({1'b0, cur_row} >= dh);

    kk_col = mirror_x ? IW'(dw_m1 - {1'b0, cur_col}) : cur_col;
    kk_row = mirror_y ? IW'(dh_m1 - {1'b0, cur_row}) : cur_row;

    div_start = cmd.start_col || cmd.start_row;
    div_kk    = cmd.start_row ? kk_row : kk_col;
    div_scale = cmd.start_row ? sh : sw;
    div_dsr   = cmd.start_row ? dh : dw;

    eor = ({1'b0, cur_col} == dw_m1);
    eof = eor && ({1'b0, cur_row} == dh_m1);
    rep = (cur_row != '0) && (row_q == prev_src_row);
  end

  nnsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .kk       (div_kk),
    .scale    (div_scale),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      prev_src_row <= '0;
    end else if (cmd.take_in) begin
      if (wrap) begin
        cur_col <= '0;
        cur_row <= '0;
      end
    end else if (cmd.load_out) begin
      if (eor) begin
        prev_src_row <= row_q;
        cur_col      <= '0;
        cur_row      <= eof ? '0 : cur_row + 1'b1;
      end else begin
        cur_col <= cur_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_col) begin
      col_q <= div_quot;
    end
    if (cmd.cap_row) begin
      row_q <= div_quot;
    end
    if (cmd.load_out) begin
      out_src_col <= col_q;
      out_src_row <= row_q;
      out_dst_col <= cur_col;
      out_dst_row <= cur_row;
      out_rep     <= rep;
      out_eor     <= eor;
      out_eof     <= eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  assign out_data = {out_dst_row, out_dst_col, out_src_row, out_src_col};
  assign out_last = out_eor;
  assign out_user = {out_eof, out_rep};

  `NNSA_ASSERT_IMPLIES(a_load_free, cmd.load_out, !out_valid || out_ready, "output overwritten")
  `NNSA_ASSERT_IMPLIES(a_eof_eor, out_valid && out_eof, out_eor, "end of frame off row end")
  `NNSA_ASSERT_IMPLIES(a_rep_row0, out_valid && out_rep, out_dst_row != '0, "repeat on row zero")

endmodule

// ----- src/nearest_neighbor_scale_addresser.sv -----
// Items are processed one at a time; each uses the shared bit-serial divider,
//   which does a registered multiply plus 25 quotient steps per axis (column, then row).
// The input is taken again as soon as a result is loaded, even while it waits on m_tready.
// Reset (rst, synchronous, active high): sizes 1, mirror off, walk at pixel (0,0),
//   no result pending. No clearing pass.
module nearest_neighbor_scale_addresser (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nnsa_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] restart, rest zero
  // result items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nnsa_pkg::OUT_TDATA_W-1:0]  m_tdata,   // src_col, src_row, dst_col, dst_row
  output logic                              m_tlast,   // end_of_row
  output logic [nnsa_pkg::OUT_TUSER_W-1:0]  m_tuser,   // row_repeat, end_of_frame
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnsa_pkg::DIM_W-1:0]        cfg_data
);

  nnsa_pkg::ctrl_cmd_t  cmd;
  nnsa_pkg::dp_status_t status;

  // Always writable, no guard; host must write registers only while no item is in flight.
  assign cfg_ready = 1'b1;

  // Sequencer: accept -> column divide -> row divide -> load output.
  nnsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: size registers, raster walk, divider, output register.
  // Source address is floor(k * src / dst), k mirrored to dst-1-k when enabled.
  nnsa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .restart   (s_tdata[0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_user  (m_tuser)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int           RANDOM_PIXELS = 1600;
  localparam int           LONG_STALL    = 400;   // receiver hold-off, in cycles
  localparam int           DRAIN_CYCLES  = 60;    // a little over one result latency
  localparam longint       TIMEOUT_NS    = 64'd800_000 * 12;
  localparam logic [nnsa_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;  // unmapped index, write ignored

  // One fetch address item as it leaves the block
  typedef struct packed {
    logic [nnsa_pkg::IDX_W-1:0] src_col;
    logic [nnsa_pkg::IDX_W-1:0] src_row;
    logic [nnsa_pkg::IDX_W-1:0] dst_col;
    logic [nnsa_pkg::IDX_W-1:0] dst_row;
    logic                       row_repeat;
    logic                       end_of_row;
    logic                       end_of_frame;
  } fetch_t;

  typedef enum logic [1:0] {
    ROW_WRITE,       // register write, block idle first
    ROW_PIXEL,       // item, checked against the predictor
    ROW_PIXEL_KNOWN  // item with the expected address typed in
  } row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [nnsa_pkg::CFG_IDX_W-1:0] idx;
    logic [nnsa_pkg::DIM_W-1:0]     val;
    bit                             restart;
    fetch_t                         want;
  } script_row_t;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [nnsa_pkg::IN_TDATA_W-1:0]     s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [nnsa_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                                m_tlast;
  logic [nnsa_pkg::OUT_TUSER_W-1:0]    m_tuser;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [nnsa_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [nnsa_pkg::DIM_W-1:0]          cfg_data;

  nearest_neighbor_scale_addresser dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [0] restart
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // src_col, src_row, dst_col, dst_row
    .m_tlast   (m_tlast),    // end_of_row
    .m_tuser   (m_tuser),    // row_repeat, end_of_frame
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the register file and of the raster walk
  logic [nnsa_pkg::DIM_W-1:0] reg_src_w = 1, reg_src_h = 1, reg_dst_w = 1, reg_dst_h = 1;
  logic                       reg_mir_x = 0, reg_mir_y = 0;
  int unsigned                walk_col = 0, walk_row = 0, prev_fetch_row = 0;

  fetch_t      fetch_queue[$];
  script_row_t script[$];
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_output   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sizes of 0 behave as 1, above MAX_DIM as MAX_DIM
  function automatic int unsigned fit_dim(input logic [nnsa_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > nnsa_pkg::MAX_DIM) return nnsa_pkg::MAX_DIM;
    return v;
  endfunction

  // Address of the next destination pixel; advances the shadow walk
  function automatic fetch_t next_fetch(input bit restart);
    int unsigned sw, sh, dw, dh, kc, kr;
    fetch_t      f;
    sw = fit_dim(reg_src_w);
    sh = fit_dim(reg_src_h);
    dw = fit_dim(reg_dst_w);
    dh = fit_dim(reg_dst_h);
    // restart, or the walk fell outside a shrunken frame
    if (restart || walk_col >= dw || walk_row >= dh) begin
      walk_col = 0;
      walk_row = 0;
    end
    kc = reg_mir_x ? dw - 1 - walk_col : walk_col;
    kr = reg_mir_y ? dh - 1 - walk_row : walk_row;
    f.src_col      = nnsa_pkg::IDX_W'((kc * sw) / dw);
    f.src_row      = nnsa_pkg::IDX_W'((kr * sh) / dh);
    f.dst_col      = nnsa_pkg::IDX_W'(walk_col);
    f.dst_row      = nnsa_pkg::IDX_W'(walk_row);
    f.row_repeat   = (walk_row != 0) && (((kr * sh) / dh) == prev_fetch_row);
    f.end_of_row   = (walk_col == dw - 1);
    f.end_of_frame = f.end_of_row && (walk_row == dh - 1);
    if (f.end_of_row) begin
      prev_fetch_row = (kr * sh) / dh;
      walk_col       = 0;
      walk_row       = f.end_of_frame ? 0 : walk_row + 1;
    end else begin
      walk_col = walk_col + 1;
    end
    return f;
  endfunction

  function automatic logic [nnsa_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(19))
      0:       return '0;
      1:       return nnsa_pkg::DIM_W'(nnsa_pkg::MAX_DIM);
      2:       return nnsa_pkg::DIM_W'($urandom_range(nnsa_pkg::MAX_DIM + 1, 8191));
      3:       return nnsa_pkg::DIM_W'($urandom_range(0, 8191));
      default: return nnsa_pkg::DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic add_write(input logic [nnsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nnsa_pkg::DIM_W-1:0] val);
    script_row_t r;
    r.kind = ROW_WRITE; r.idx = idx; r.val = val; r.restart = 0; r.want = '0;
    script.push_back(r);
  endtask

  task automatic add_pixel(input bit restart);
    script_row_t r;
    r.kind = ROW_PIXEL; r.idx = '0; r.val = '0; r.restart = restart; r.want = '0;
    script.push_back(r);
  endtask

  task automatic add_known(input bit restart, input int sc, input int sr, input int dc,
                           input int dr, input bit rep, input bit eor, input bit eof);
    script_row_t r;
    r.kind = ROW_PIXEL_KNOWN; r.idx = '0; r.val = '0; r.restart = restart;
    r.want = '{nnsa_pkg::IDX_W'(sc), nnsa_pkg::IDX_W'(sr), nnsa_pkg::IDX_W'(dc),
               nnsa_pkg::IDX_W'(dr), rep, eor, eof};
    script.push_back(r);
  endtask

  // Register write; valid drops again once the write is taken
  task automatic write_reg(input logic [nnsa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nnsa_pkg::DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      nnsa_pkg::REG_SRC_WIDTH:  reg_src_w = val;
      nnsa_pkg::REG_SRC_HEIGHT: reg_src_h = val;
      nnsa_pkg::REG_DST_WIDTH:  reg_dst_w = val;
      nnsa_pkg::REG_DST_HEIGHT: reg_dst_h = val;
      nnsa_pkg::REG_MIRROR_X:   reg_mir_x = val[0];
      nnsa_pkg::REG_MIRROR_Y:   reg_mir_y = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item; tvalid stays high on return so back-to-back items need no toggle
  task automatic send_pixel(input bit restart, input bit known, input fetch_t want);
    fetch_t f;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= nnsa_pkg::IN_TDATA_W'(restart);
    do @(posedge clk); while (!s_tready);
    f = next_fetch(restart);
    fetch_queue.push_back(known ? want : f);
  endtask

  // Stop offering and wait for every outstanding address
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (fetch_queue.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Output side: ready pattern plus the one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 0;
        m_tready <= 1'b0;
        for (int n = 0; n < LONG_STALL; n++) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted item with the oldest expected address
  always @(posedge clk) begin
    fetch_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (fetch_queue.size() == 0) begin
        mismatches++;
        $display("%0t ns: item with none expected, expected nothing, actual %h %b %h",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = fetch_queue.pop_front();
        check_field("src_col",      want.src_col,      m_tdata[nnsa_pkg::IDX_W-1:0]);
        check_field("src_row",      want.src_row,
                    m_tdata[2*nnsa_pkg::IDX_W-1:nnsa_pkg::IDX_W]);
        check_field("dst_col",      want.dst_col,
                    m_tdata[3*nnsa_pkg::IDX_W-1:2*nnsa_pkg::IDX_W]);
        check_field("dst_row",      want.dst_row,
                    m_tdata[4*nnsa_pkg::IDX_W-1:3*nnsa_pkg::IDX_W]);
        check_field("row_repeat",   want.row_repeat,   m_tuser[0]);
        check_field("end_of_row",   want.end_of_row,   m_tlast);
        check_field("end_of_frame", want.end_of_frame, m_tuser[1]);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    int  rand_sent;
    int  n;
    bit  held;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rand_sent = 0;
    held      = 0;

    // Directed part
    add_known(0, 0, 0, 0, 0, 0, 1, 1);           // reset sizes: 1x1 frame
    add_known(1, 0, 0, 0, 0, 0, 1, 1);
    add_write(nnsa_pkg::REG_SRC_WIDTH, 13'd4096);
    add_write(nnsa_pkg::REG_DST_WIDTH, 13'd4096);
    add_write(nnsa_pkg::REG_MIRROR_X, 13'h1FFF);  // upper bits ignored
    add_known(1, 4095, 0, 0, 0, 0, 0, 0);         // mirrored: last source column
    add_known(0, 4094, 0, 1, 0, 0, 0, 0);
    add_write(nnsa_pkg::REG_DST_WIDTH, 13'd0);    // zero width acts as one
    add_known(0, 0, 0, 0, 0, 0, 1, 1);            // walk now outside: restarts
    add_write(nnsa_pkg::REG_SRC_HEIGHT, 13'h1FFF); // clamps to MAX_DIM
    add_write(nnsa_pkg::REG_DST_HEIGHT, 13'd4096);
    add_write(nnsa_pkg::REG_MIRROR_Y, 13'd1);
    add_write(nnsa_pkg::REG_DST_WIDTH, 13'd2);
    add_write(nnsa_pkg::REG_SRC_WIDTH, 13'd3);
    add_write(nnsa_pkg::REG_MIRROR_X, 13'h1FFE);
    add_known(1, 0, 4095, 0, 0, 0, 0, 0);
    add_known(0, 1, 4095, 1, 0, 0, 1, 0);
    add_known(0, 0, 4094, 0, 1, 0, 0, 0);
    add_pixel(0);
    add_write(nnsa_pkg::REG_SRC_HEIGHT, 13'd2);
    add_write(nnsa_pkg::REG_DST_HEIGHT, 13'd5);
    add_write(nnsa_pkg::REG_MIRROR_Y, 13'd0);
    add_write(REG_SPARE, 13'h1555);
    for (int i = 0; i < 12; i++) add_pixel(i == 7);  // repeated rows, wrap, restart
    add_write(nnsa_pkg::REG_SRC_WIDTH, 13'd1);
    add_write(nnsa_pkg::REG_DST_WIDTH, 13'd4096);
    add_pixel(1);
    add_pixel(0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (i == 0 || script[i-1].kind != ROW_WRITE) settle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_pixel(script[i].restart, script[i].kind == ROW_PIXEL_KNOWN, script[i].want);
      end
    end

    // Random phases: new settings while idle, then a run of raster items
    while (rand_sent < RANDOM_PIXELS) begin
      if (rand_sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 60;
      end else if (rand_sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      if ($urandom_range(1)) write_reg(nnsa_pkg::REG_SRC_WIDTH,  pick_dim());
      if ($urandom_range(1)) write_reg(nnsa_pkg::REG_SRC_HEIGHT, pick_dim());
      if ($urandom_range(1)) write_reg(nnsa_pkg::REG_DST_WIDTH,  pick_dim());
      if ($urandom_range(1)) write_reg(nnsa_pkg::REG_DST_HEIGHT, pick_dim());
      if ($urandom_range(2) == 0)
        write_reg(nnsa_pkg::REG_MIRROR_X, nnsa_pkg::DIM_W'($urandom_range(0, 8191)));
      if ($urandom_range(2) == 0)
        write_reg(nnsa_pkg::REG_MIRROR_Y, nnsa_pkg::DIM_W'($urandom_range(0, 8191)));
      if ($urandom_range(19) == 0)
        write_reg(REG_SPARE, nnsa_pkg::DIM_W'($urandom_range(0, 8191)));
      n = $urandom_range(4, 60);
      // once, with the sender at full rate, back up the output and stall the input
      if (!held && send_idle_pct == 0) begin
        held        = 1;
        hold_output = 1;
        n           = 40;
      end
      repeat (n) begin
        send_pixel($urandom_range(24) == 0, 0, '0);
        rand_sent++;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && fetch_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
